/* rtl/rpchp_pkg.sv */
package rpchp_pkg;

    localparam int RECORD_LEN_BITS_DEF = 31;

    localparam logic [31:0] CALL_TYPE_RESET  = 32'd0;
    localparam logic [31:0] PROTO_VERS_RESET = 32'd2;

    localparam logic CFG_CALL_TYPE  = 1'b0;
    localparam logic CFG_PROTO_VERS = 1'b1;

    localparam logic [3:0] PH_MARK  = 4'd0;
    localparam logic [3:0] PH_XID   = 4'd1;
    localparam logic [3:0] PH_TYPE  = 4'd2;
    localparam logic [3:0] PH_RVERS = 4'd3;
    localparam logic [3:0] PH_PROG  = 4'd4;
    localparam logic [3:0] PH_PVERS = 4'd5;
    localparam logic [3:0] PH_PROC  = 4'd6;
    localparam logic [3:0] PH_CFLAV = 4'd7;
    localparam logic [3:0] PH_CLEN  = 4'd8;
    localparam logic [3:0] PH_CSKIP = 4'd9;
    localparam logic [3:0] PH_VFLAV = 4'd10;
    localparam logic [3:0] PH_VLEN  = 4'd11;
    localparam logic [3:0] PH_VSKIP = 4'd12;
    localparam logic [3:0] PH_BODY  = 4'd13;
    localparam logic [3:0] PH_DROP  = 4'd14;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [2:0] CAUSE_SHORT     = 3'd0;
    localparam logic [2:0] CAUSE_NOT_CALL  = 3'd1;
    localparam logic [2:0] CAUSE_RPC_VERS  = 3'd2;
    localparam logic [2:0] CAUSE_CRED_OVF  = 3'd3;
    localparam logic [2:0] CAUSE_VERF_OVF  = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] xid;
        logic [31:0] program_res;
        logic [31:0] prog_version;
        logic [31:0] procedure;
        logic [7:0]  body_byte;
        logic        last;
        logic [2:0]  cause;
    } result_t;

endpackage

/* rtl/rpc_record_call_header_parser.sv */
// RPC record-marked call header parser.
// Input channel in_valid/in_ready/in_byte carries the stream one byte per word.
// Each record opens with a 4-byte big-endian marker; its low RECORD_LEN_BITS
// bits give the record length. The call header (xid, type, RPC version,
// program, version, procedure, credential, verifier) is parsed, then one
// header result and one body-byte result per remaining record byte follow.
// A failed check gives one reject result with a cause; the rest of the
// record is dropped. Results leave on out_valid/out_ready.
// Each byte is handled in the cycle it is accepted. One byte per cycle is
// sustained while in_ready is high; the per-byte state update and length
// compare set this. A two-entry output stage (output register plus skid)
// lets a byte be taken while a result waits; when both hold a result,
// in_ready drops until the receiver takes one. Reset clears the parser to
// await a record marker, empties the output stage and loads the register
// defaults (call type 0, RPC version 2). The user makes configuration
// writes via cfg_we only while idle; the block does not enforce this.
module rpc_record_call_header_parser #(
    parameter int RECORD_LEN_BITS = rpchp_pkg::RECORD_LEN_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [31:0] xid,
    output logic [31:0] program_res,
    output logic [31:0] prog_version,
    output logic [31:0] procedure,
    output logic [7:0]  body_byte,
    output logic        last_of_record,
    output logic [2:0]  reject_cause
);
    import rpchp_pkg::*;

    localparam int LW = RECORD_LEN_BITS;

    logic [31:0]    call_type_reg;
    logic [31:0]    proto_vers_reg;

    logic [3:0]     phase_reg, phase_next;
    logic [1:0]     byte_cnt_reg, byte_cnt_next;
    logic [23:0]    shift_reg, shift_next;
    logic [LW-1:0]  bytes_left_reg, bytes_left_next;
    logic [LW-1:0]  skip_reg, skip_next;
    logic [31:0]    xid_reg, xid_next;
    logic [31:0]    prog_reg, prog_next;
    logic [31:0]    vers_reg, vers_next;
    logic [31:0]    proc_reg, proc_next;
    logic           type_bad_reg, type_bad_next;

    logic           out_valid_reg, out_valid_next;
    result_t        out_reg, out_next;
    logic           skid_valid_reg, skid_valid_next;
    result_t        skid_reg, skid_next;

    logic           accept;
    logic           out_fire;
    logic [31:0]    w;
    logic           word_done;
    logic [LW-1:0]  bl_dec;
    logic           bl_zero;
    logic [33:0]    w_pad;
    logic           pad_over;
    logic           pad_zero;
    logic           rej;
    logic [2:0]     rej_cause;
    logic           hdr;
    logic           res_valid;
    result_t        res;

    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    assign w         = {shift_reg, in_byte};
    assign word_done = (byte_cnt_reg == 2'd3);
    assign bl_dec    = bytes_left_reg - {{(LW-1){1'b0}}, 1'b1};
    assign bl_zero   = (bl_dec == '0);
    assign w_pad     = {2'b00, w} + {32'd0, (~w[1:0]) + 2'd1};
    assign pad_over  = w_pad > {{(34-LW){1'b0}}, bl_dec};
    assign pad_zero  = (w_pad == 34'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            call_type_reg  <= CALL_TYPE_RESET;
            proto_vers_reg <= PROTO_VERS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CALL_TYPE:  call_type_reg  <= cfg_wdata;
                CFG_PROTO_VERS: proto_vers_reg <= cfg_wdata;
                default:        call_type_reg  <= call_type_reg;
            endcase
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        byte_cnt_next   = byte_cnt_reg;
        shift_next      = shift_reg;
        bytes_left_next = bytes_left_reg;
        skip_next       = skip_reg;
        xid_next        = xid_reg;
        prog_next       = prog_reg;
        vers_next       = vers_reg;
        proc_next       = proc_reg;
        type_bad_next   = type_bad_reg;
        rej             = 1'b0;
        rej_cause       = CAUSE_SHORT;
        hdr             = 1'b0;
        res_valid       = 1'b0;
        res             = '0;

        if (accept)
        begin
            if (phase_reg == PH_MARK)
            begin
                shift_next    = w[23:0];
                byte_cnt_next = byte_cnt_reg + 2'd1;
                if (word_done)
                begin
                    bytes_left_next = w[LW-1:0];
                    if (w[LW-1:0] == '0)
                        rej = 1'b1;
                    else
                        phase_next = PH_XID;
                end
            end
            else
            begin
                bytes_left_next = bl_dec;
                unique case (phase_reg)
                    PH_DROP:
                    begin
                        if (bl_zero)
                            phase_next = PH_MARK;
                    end
                    PH_BODY:
                    begin
                        res_valid     = 1'b1;
                        res.kind      = KIND_BODY;
                        res.body_byte = in_byte;
                        res.last      = bl_zero;
                        if (bl_zero)
                            phase_next = PH_MARK;
                    end
                    PH_CSKIP, PH_VSKIP:
                    begin
                        skip_next = skip_reg - {{(LW-1){1'b0}}, 1'b1};
                        if (skip_reg == {{(LW-1){1'b0}}, 1'b1})
                        begin
                            if (phase_reg == PH_VSKIP)
                                hdr = 1'b1;
                            else
                            begin
                                phase_next = PH_VFLAV;
                                rej        = bl_zero;
                            end
                        end
                    end
                    PH_XID, PH_TYPE, PH_RVERS, PH_PROG, PH_PVERS, PH_PROC,
                    PH_CFLAV, PH_CLEN, PH_VFLAV, PH_VLEN:
                    begin
                        shift_next    = w[23:0];
                        byte_cnt_next = byte_cnt_reg + 2'd1;
                        if (!word_done)
                            rej = bl_zero;
                        else
                        begin
                            rej = bl_zero;
                            unique case (phase_reg)
                                PH_XID:
                                begin
                                    xid_next   = w;
                                    phase_next = PH_TYPE;
                                end
                                PH_TYPE:
                                begin
                                    type_bad_next = (w != call_type_reg);
                                    phase_next    = PH_RVERS;
                                end
                                PH_RVERS:
                                begin
                                    phase_next = PH_PROG;
                                    if (type_bad_reg)
                                    begin
                                        rej       = 1'b1;
                                        rej_cause = CAUSE_NOT_CALL;
                                    end
                                    else if (w != proto_vers_reg)
                                    begin
                                        rej       = 1'b1;
                                        rej_cause = CAUSE_RPC_VERS;
                                    end
                                end
                                PH_PROG:
                                begin
                                    prog_next  = w;
                                    phase_next = PH_PVERS;
                                end
                                PH_PVERS:
                                begin
                                    vers_next  = w;
                                    phase_next = PH_PROC;
                                end
                                PH_PROC:
                                begin
                                    proc_next  = w;
                                    phase_next = PH_CFLAV;
                                end
                                PH_CFLAV:
                                begin
                                    phase_next = PH_CLEN;
                                end
                                PH_CLEN:
                                begin
                                    skip_next = w_pad[LW-1:0];
                                    if (pad_over)
                                    begin
                                        rej       = 1'b1;
                                        rej_cause = CAUSE_CRED_OVF;
                                    end
                                    else
                                        phase_next = pad_zero ? PH_VFLAV : PH_CSKIP;
                                end
                                PH_VFLAV:
                                begin
                                    phase_next = PH_VLEN;
                                end
                                default:
                                begin
                                    skip_next = w_pad[LW-1:0];
                                    rej       = 1'b0;
                                    if (pad_over)
                                    begin
                                        rej       = 1'b1;
                                        rej_cause = CAUSE_VERF_OVF;
                                    end
                                    else if (pad_zero)
                                        hdr = 1'b1;
                                    else
                                        phase_next = PH_VSKIP;
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                        phase_next = PH_MARK;
                    end
                endcase
            end

            if (rej)
            begin
                res_valid     = 1'b1;
                res           = '0;
                res.kind      = KIND_REJECT;
                res.last      = 1'b1;
                res.cause     = rej_cause;
                byte_cnt_next = 2'd0;
                if (phase_reg == PH_MARK || bl_zero)
                    phase_next = PH_MARK;
                else
                    phase_next = PH_DROP;
            end
            else if (hdr)
            begin
                res_valid        = 1'b1;
                res              = '0;
                res.kind         = KIND_HEADER;
                res.xid          = xid_reg;
                res.program_res  = prog_reg;
                res.prog_version = vers_reg;
                res.procedure    = proc_reg;
                res.last         = bl_zero;
                phase_next       = bl_zero ? PH_MARK : PH_BODY;
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MARK;
            byte_cnt_reg   <= 2'd0;
            shift_reg      <= '0;
            bytes_left_reg <= '0;
            skip_reg       <= '0;
            xid_reg        <= '0;
            prog_reg       <= '0;
            vers_reg       <= '0;
            proc_reg       <= '0;
            type_bad_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_cnt_reg   <= byte_cnt_next;
            shift_reg      <= shift_next;
            bytes_left_reg <= bytes_left_next;
            skip_reg       <= skip_next;
            xid_reg        <= xid_next;
            prog_reg       <= prog_next;
            vers_reg       <= vers_next;
            proc_reg       <= proc_next;
            type_bad_reg   <= type_bad_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = out_reg.kind;
    assign xid            = out_reg.xid;
    assign program_res    = out_reg.program_res;
    assign prog_version   = out_reg.prog_version;
    assign procedure      = out_reg.procedure;
    assign body_byte      = out_reg.body_byte;
    assign last_of_record = out_reg.last;
    assign reject_cause   = out_reg.cause;

endmodule

/* dv/tb_rpc_record_call_header_parser.sv */
module tb_rpc_record_call_header_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import rpchp_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam logic [30:0] LEN_MASK = 31'((64'd1 << RECORD_LEN_BITS_DEF) - 64'd1);

    typedef struct packed {
        logic        frag;
        logic [30:0] len;
        logic [31:0] xid, mtype, rvers, prog, pvers, proc, cflav, clen, vflav, vlen;
    } call_rec_t;

    typedef struct packed {
        logic        frag;
        logic [30:0] len;
        logic [31:0] fill;
        logic [31:0] mtype;
        logic [31:0] rvers;
        logic [31:0] clen;
        logic [31:0] vlen;
        logic        typed;
        logic [1:0]  kind;
        logic [2:0]  cause;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_wdata = 32'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  result_kind;
    logic [31:0] xid;
    logic [31:0] program_res;
    logic [31:0] prog_version;
    logic [31:0] procedure;
    logic [7:0]  body_byte;
    logic        last_of_record;
    logic [2:0]  reject_cause;

    rpc_record_call_header_parser dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .xid            (xid),
        .program_res    (program_res),
        .prog_version   (prog_version),
        .procedure      (procedure),
        .body_byte      (body_byte),
        .last_of_record (last_of_record),
        .reject_cause   (reject_cause)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // parser state mirror
    logic [31:0] call_type_cfg = CALL_TYPE_RESET;
    logic [31:0] proto_vers_cfg = PROTO_VERS_RESET;
    logic [3:0]  parse_phase = PH_MARK;
    logic [1:0]  word_pos = 2'd0;
    logic [31:0] word_acc = 32'd0;
    logic [30:0] record_left = 31'd0;
    logic [33:0] skip_count = 34'd0;
    logic [31:0] held_xid = 32'd0;
    logic [31:0] held_prog = 32'd0;
    logic [31:0] held_pvers = 32'd0;
    logic [31:0] held_proc = 32'd0;
    logic        type_mismatch = 1'b0;

    result_t     results_due[$];
    result_t     taken_result;
    result_t     want;
    logic        in_take = 1'b0;
    logic        out_take = 1'b0;
    logic        typed_row = 1'b0;
    logic        calm = 1'b0;
    int          errors = 0;
    int          stuck_cycles = 0;
    int unsigned bytes_sent = 0;

    dir_row_t directed_rows[17] = '{
        '{1'b1, 31'd0,  32'h0000_0000, 32'd0, 32'd2, 32'd0, 32'd0, 1'b1, KIND_REJECT, CAUSE_SHORT},
        '{1'b0, 31'd3,  32'hFFFF_FFFF, 32'd0, 32'd2, 32'd0, 32'd0, 1'b1, KIND_REJECT, CAUSE_SHORT},
        '{1'b1, 31'd8,  32'h0000_0000, 32'd0, 32'd2, 32'd0, 32'd0, 1'b1, KIND_REJECT, CAUSE_SHORT},
        '{1'b0, 31'd10, 32'h0000_0000, 32'd7, 32'd2, 32'd0, 32'd0, 1'b1, KIND_REJECT, CAUSE_SHORT},
        '{1'b0, 31'd12, 32'h0000_0000, 32'd1, 32'd2, 32'd0, 32'd0, 1'b1, KIND_REJECT,
          CAUSE_NOT_CALL},
        '{1'b0, 31'd60, 32'h0000_0000, 32'hFFFF_FFFF, 32'd7, 32'd0, 32'd0, 1'b1, KIND_REJECT,
          CAUSE_NOT_CALL},
        '{1'b1, 31'd12, 32'h0000_0000, 32'd0, 32'd3, 32'd0, 32'd0, 1'b1, KIND_REJECT,
          CAUSE_RPC_VERS},
        '{1'b0, 31'd40, 32'h0000_0000, 32'd0, 32'd2, 32'hFFFF_FFFF, 32'd0, 1'b1, KIND_REJECT,
          CAUSE_CRED_OVF},
        '{1'b0, 31'd38, 32'h0000_0000, 32'd0, 32'd2, 32'd5, 32'd0, 1'b1, KIND_REJECT,
          CAUSE_CRED_OVF},
        '{1'b0, 31'd36, 32'h0000_0000, 32'd0, 32'd2, 32'd4, 32'd0, 1'b1, KIND_REJECT, CAUSE_SHORT},
        '{1'b0, 31'd36, 32'h0000_0000, 32'd0, 32'd2, 32'd0, 32'd0, 1'b1, KIND_REJECT, CAUSE_SHORT},
        '{1'b1, 31'd40, 32'hFFFF_FFFF, 32'd0, 32'd2, 32'd0, 32'd0, 1'b1, KIND_HEADER, CAUSE_SHORT},
        '{1'b0, 31'd48, 32'h0000_0000, 32'd0, 32'd2, 32'd0, 32'd9, 1'b1, KIND_REJECT,
          CAUSE_VERF_OVF},
        '{1'b0, 31'd48, 32'h8000_0001, 32'd0, 32'd2, 32'd0, 32'd8, 1'b1, KIND_HEADER, CAUSE_SHORT},
        '{1'b0, 31'd47, 32'h0000_0000, 32'd0, 32'd2, 32'd1, 32'd1, 1'b1, KIND_REJECT,
          CAUSE_VERF_OVF},
        '{1'b0, 31'd52, 32'h1234_5678, 32'd0, 32'd2, 32'd3, 32'd0, 1'b0, KIND_HEADER, CAUSE_SHORT},
        '{1'b1, 31'd41, 32'hA5C3_0F96, 32'd0, 32'd2, 32'd0, 32'd0, 1'b0, KIND_HEADER, CAUSE_SHORT}
    };

    function automatic logic [33:0] padded_len(logic [31:0] n);
        return {2'b00, n} + {32'd0, 2'(2'd0 - n[1:0])};
    endfunction

    function automatic result_t reject_result(logic [2:0] cause);
        result_t r;
        r = '0;
        r.kind = KIND_REJECT;
        r.last = 1'b1;
        r.cause = cause;
        word_pos = 2'd0;
        word_acc = 32'd0;
        parse_phase = (record_left == 0) ? PH_MARK : PH_DROP;
        return r;
    endfunction

    function automatic result_t header_result();
        result_t r;
        r = '0;
        r.kind = KIND_HEADER;
        r.xid = held_xid;
        r.program_res = held_prog;
        r.prog_version = held_pvers;
        r.procedure = held_proc;
        r.last = (record_left == 0);
        parse_phase = (record_left == 0) ? PH_MARK : PH_BODY;
        return r;
    endfunction

    task automatic parse_byte(input logic [7:0] b, output logic got, output result_t r);
        logic [31:0] w;
        got = 1'b0;
        r = '0;
        if (parse_phase == PH_MARK)
        begin
            word_acc = {word_acc[23:0], b};
            word_pos = word_pos + 2'd1;
            if (word_pos != 0)
                return;
            record_left = word_acc[30:0] & LEN_MASK;
            word_acc = 32'd0;
            if (record_left == 0)
            begin
                r = reject_result(CAUSE_SHORT);
                got = 1'b1;
            end
            else
                parse_phase = PH_XID;
            return;
        end
        record_left = record_left - 31'd1;
        case (parse_phase)
            PH_DROP:
            begin
                if (record_left == 0)
                    parse_phase = PH_MARK;
                return;
            end
            PH_BODY:
            begin
                r.kind = KIND_BODY;
                r.body_byte = b;
                r.last = (record_left == 0);
                if (record_left == 0)
                    parse_phase = PH_MARK;
                got = 1'b1;
                return;
            end
            PH_CSKIP, PH_VSKIP:
            begin
                skip_count = skip_count - 34'd1;
                if (skip_count != 0)
                    return;
                if (parse_phase == PH_VSKIP)
                begin
                    r = header_result();
                    got = 1'b1;
                    return;
                end
                parse_phase = PH_VFLAV;
                if (record_left == 0)
                begin
                    r = reject_result(CAUSE_SHORT);
                    got = 1'b1;
                end
                return;
            end
            default:
            begin
            end
        endcase
        word_acc = {word_acc[23:0], b};
        word_pos = word_pos + 2'd1;
        if (word_pos != 0)
        begin
            if (record_left == 0)
            begin
                r = reject_result(CAUSE_SHORT);
                got = 1'b1;
            end
            return;
        end
        w = word_acc;
        word_acc = 32'd0;
        case (parse_phase)
            PH_XID:
            begin
                held_xid = w;
                parse_phase = PH_TYPE;
            end
            PH_TYPE:
            begin
                type_mismatch = (w != call_type_cfg);
                parse_phase = PH_RVERS;
            end
            PH_RVERS:
            begin
                got = 1'b1;
                if (type_mismatch)
                begin
                    r = reject_result(CAUSE_NOT_CALL);
                    return;
                end
                if (w != proto_vers_cfg)
                begin
                    r = reject_result(CAUSE_RPC_VERS);
                    return;
                end
                got = 1'b0;
                parse_phase = PH_PROG;
            end
            PH_PROG:
            begin
                held_prog = w;
                parse_phase = PH_PVERS;
            end
            PH_PVERS:
            begin
                held_pvers = w;
                parse_phase = PH_PROC;
            end
            PH_PROC:
            begin
                held_proc = w;
                parse_phase = PH_CFLAV;
            end
            PH_CFLAV:
                parse_phase = PH_CLEN;
            PH_CLEN:
            begin
                skip_count = padded_len(w);
                if (skip_count > record_left)
                begin
                    r = reject_result(CAUSE_CRED_OVF);
                    got = 1'b1;
                    return;
                end
                parse_phase = (skip_count != 0) ? PH_CSKIP : PH_VFLAV;
            end
            PH_VFLAV:
                parse_phase = PH_VLEN;
            default:
            begin
                skip_count = padded_len(w);
                got = 1'b1;
                if (skip_count > record_left)
                    r = reject_result(CAUSE_VERF_OVF);
                else if (skip_count == 0)
                    r = header_result();
                else
                begin
                    got = 1'b0;
                    parse_phase = PH_VSKIP;
                end
                return;
            end
        endcase
        if (record_left == 0)
        begin
            r = reject_result(CAUSE_SHORT);
            got = 1'b1;
        end
    endtask

    function automatic logic [7:0] record_byte(call_rec_t c, longint unsigned pos);
        logic [31:0] w;
        longint unsigned cred_end;
        cred_end = 64'(padded_len(c.clen)) + 64'd32;
        if (pos < 32)
        begin
            case (pos / 4)
                0: w = c.xid;
                1: w = c.mtype;
                2: w = c.rvers;
                3: w = c.prog;
                4: w = c.pvers;
                5: w = c.proc;
                6: w = c.cflav;
                default: w = c.clen;
            endcase
            return 8'(w >> (8 * (3 - pos % 4)));
        end
        if (pos >= cred_end && pos < cred_end + 8)
        begin
            w = (pos < cred_end + 4) ? c.vflav : c.vlen;
            return 8'(w >> (8 * (3 - (pos - cred_end) % 4)));
        end
        return 8'($urandom);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        logic    got;
        result_t r;
        if (!calm && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        do
            @(posedge clk);
        while (!in_take);
        bytes_sent++;
        parse_byte(b, got, r);
        if (got && !typed_row)
            results_due.push_back(r);
    endtask

    task automatic send_call(input call_rec_t c);
        logic [31:0] marker;
        marker = {c.frag, c.len};
        for (int k = 3; k >= 0; k--)
            send_byte(marker[8 * k +: 8]);
        for (longint unsigned i = 0; i < c.len; i++)
            send_byte(record_byte(c, i));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_due.size() != 0);
    endtask

    task automatic set_config(input logic [31:0] call_type, input logic [31:0] proto_vers);
        cfg_we <= 1'b1;
        cfg_index <= CFG_CALL_TYPE;
        cfg_wdata <= call_type;
        @(posedge clk);
        cfg_index <= CFG_PROTO_VERS;
        cfg_wdata <= proto_vers;
        @(posedge clk);
        cfg_we <= 1'b0;
        call_type_cfg = call_type;
        proto_vers_cfg = proto_vers;
    endtask

    task automatic random_call(output call_rec_t c);
        int unsigned roll;
        logic [33:0] hdr;
        roll = $urandom_range(99);
        c.frag = 1'($urandom);
        c.xid = $urandom;
        c.prog = $urandom;
        c.pvers = $urandom;
        c.proc = $urandom;
        c.cflav = $urandom;
        c.vflav = $urandom;
        c.mtype = call_type_cfg;
        c.rvers = proto_vers_cfg;
        c.clen = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12);
        c.vlen = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12);
        hdr = 34'd40 + padded_len(c.clen) + padded_len(c.vlen);
        c.len = 31'(hdr + (($urandom_range(9) == 0) ? $urandom_range(200, 25) : $urandom_range(24)));
        if (roll < 7)
            c.mtype = c.mtype ^ (32'd1 << $urandom_range(31));
        else if (roll < 14)
            c.rvers = c.rvers ^ (32'd1 << $urandom_range(31));
        else if (roll < 22)
            c.len = 31'($urandom_range(c.len));
        else if (roll < 25)
            c.clen = $urandom | 32'h0000_1000;
        else if (roll < 29)
            c.clen = 32'(c.len) - 32'd35 + $urandom_range(6);
        else if (roll < 32)
            c.vlen = $urandom | 32'h0000_1000;
        else if (roll < 36)
            c.vlen = 32'(c.len) - 32'd41 - 32'(padded_len(c.clen)) + $urandom_range(3);
        else if (roll < 40)
        begin
            c.len = 31'($urandom_range(64));
            c.mtype = $urandom;
            c.rvers = $urandom_range(3);
        end
    endtask

    always @(negedge clk)
    begin
        in_take = rst_n && in_valid && in_ready;
        out_take = rst_n && out_valid && out_ready;
        taken_result = '{result_kind, xid, program_res, prog_version, procedure, body_byte,
                         last_of_record, reject_cause};
    end

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 12);
    end

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (out_take)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t unexpected word: expected none actual kind %0d", $time,
                         taken_result.kind);
                errors++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("result_kind", 32'(want.kind), 32'(taken_result.kind));
                check_field("xid", want.xid, taken_result.xid);
                check_field("program_res", want.program_res, taken_result.program_res);
                check_field("prog_version", want.prog_version, taken_result.prog_version);
                check_field("procedure", want.procedure, taken_result.procedure);
                check_field("body_byte", 32'(want.body_byte), 32'(taken_result.body_byte));
                check_field("last_of_record", 32'(want.last), 32'(taken_result.last));
                check_field("reject_cause", 32'(want.cause), 32'(taken_result.cause));
            end
        end
    end

    always @(posedge clk)
    begin
        if (in_take || out_take || !rst_n)
            stuck_cycles <= 0;
        else if (stuck_cycles >= STALL_LIMIT)
        begin
            $display("FAIL rpc_record_call_header_parser");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        dir_row_t    row;
        call_rec_t   c;
        result_t     typed_want;
        int unsigned goal;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            c.frag = row.frag;
            c.len = row.len;
            c.xid = row.fill;
            c.prog = row.fill;
            c.pvers = row.fill;
            c.proc = row.fill;
            c.cflav = row.fill;
            c.vflav = row.fill;
            c.mtype = row.mtype;
            c.rvers = row.rvers;
            c.clen = row.clen;
            c.vlen = row.vlen;
            typed_row = row.typed;
            if (row.typed)
            begin
                typed_want = '0;
                typed_want.kind = row.kind;
                typed_want.last = 1'b1;
                if (row.kind == KIND_REJECT)
                    typed_want.cause = row.cause;
                else
                begin
                    typed_want.xid = row.fill;
                    typed_want.program_res = row.fill;
                    typed_want.prog_version = row.fill;
                    typed_want.procedure = row.fill;
                end
                results_due.push_back(typed_want);
            end
            send_call(c);
        end
        typed_row = 1'b0;
        for (int p = 0; p < 4; p++)
        begin
            drain_results();
            repeat (2) @(posedge clk);
            case (p)
                0: set_config($urandom, $urandom);
                1: set_config(32'hFFFF_FFFF, 32'h0000_0000);
                2: set_config(32'h0000_0000, 32'hFFFF_FFFF);
                default: set_config(CALL_TYPE_RESET, PROTO_VERS_RESET);
            endcase
            calm = (p == 2);
            goal = bytes_sent + 250;
            while (bytes_sent < goal)
            begin
                random_call(c);
                send_call(c);
                if ($urandom_range(99) < 3)
                    drain_results();
            end
        end
        calm = 1'b0;
        drain_results();
        repeat (8) @(posedge clk);
        if (errors == 0 && results_due.size() == 0)
            $display("PASS rpc_record_call_header_parser");
        else
            $display("FAIL rpc_record_call_header_parser");
        $finish;
    end

endmodule
